/* rtl/core/lbps_pkg.sv */
`default_nettype none
package lbps_pkg;

  // Table sizes and the widths that follow from them.
  localparam int STEP_DEPTH = 32;
  localparam int NOTE_DEPTH = 32;
  localparam int STEP_AW    = $clog2(STEP_DEPTH);
  localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
  localparam int POS_W      = 6;

  // Command codes.
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_WRITE_STEP = 3'd1;
  localparam logic [2:0] CMD_WRITE_NOTE = 3'd2;
  localparam logic [2:0] CMD_START_ANIM = 3'd3;
  localparam logic [2:0] CMD_START_MEL  = 3'd4;
  localparam logic [2:0] CMD_TONE       = 3'd5;

  // Status classes.
  localparam logic [2:0] CLS_YELLOW  = 3'd0;
  localparam logic [2:0] CLS_BLUE    = 3'd1;
  localparam logic [2:0] CLS_GREEN   = 3'd2;
  localparam logic [2:0] CLS_CYAN    = 3'd3;
  localparam logic [2:0] CLS_MAGENTA = 3'd4;
  localparam logic [2:0] CLS_ERROR   = 3'd5;

  // LED colors, bit 2 red, bit 1 green, bit 0 blue.
  localparam logic [2:0] RGB_OFF     = 3'b000;
  localparam logic [2:0] RGB_BLUE    = 3'b001;
  localparam logic [2:0] RGB_GREEN   = 3'b010;
  localparam logic [2:0] RGB_CYAN    = 3'b011;
  localparam logic [2:0] RGB_RED     = 3'b100;
  localparam logic [2:0] RGB_MAGENTA = 3'b101;
  localparam logic [2:0] RGB_YELLOW  = 3'b110;

  // Configuration register indexes and reset values.
  localparam logic CFG_DEFAULT_TONE_FREQ = 1'b0;
  localparam logic CFG_BLINK_INTERVAL    = 1'b1;
  localparam logic [15:0] DEFAULT_TONE_FREQ_RST = 16'd2000;
  localparam logic [15:0] BLINK_INTERVAL_RST    = 16'd250;

  // One request as it arrives.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  entry_index;
    logic        color_keep;
    logic [2:0]  color_rgb;
    logic [15:0] tone_freq;
    logic [15:0] tone_duration;
    logic [15:0] step_duration;
    logic [5:0]  sequence_count;
    logic [2:0]  status_class;
  } item_t;

  // One animation step.
  typedef struct packed {
    logic        keep;
    logic [2:0]  rgb;
    logic [15:0] freq;
    logic [15:0] tdur;
    logic [15:0] sdur;
  } step_t;

  // One melody note.
  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] dur;
  } note_t;

  // Table write control.
  typedef struct packed {
    logic              step_we;
    logic              note_we;
    logic [STEP_AW-1:0] step_index;
    logic [NOTE_AW-1:0] note_index;
  } tbl_wr_t;

endpackage
`default_nettype wire

/* rtl/core/lbps_in_stage.sv */
`default_nettype none
module lbps_in_stage
  import lbps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire logic  proc_ready,
  output logic       item_valid,
  output item_t      item
);

  // The register holds its request until the processing stage takes it.
  assign in_stall = item_valid && !proc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lbps_tables.sv */
`default_nettype none
module lbps_tables
  import lbps_pkg::*;
(
  input  wire logic               clk,
  input  wire tbl_wr_t            wr,
  input  wire step_t              step_wdata,
  input  wire note_t              note_wdata,
  input  wire logic [STEP_AW-1:0] step_raddr,
  input  wire logic [NOTE_AW-1:0] note_raddr,
  output step_t                   step_rdata,
  output note_t                   note_rdata
);

  step_t step_mem [STEP_DEPTH];
  note_t note_mem [NOTE_DEPTH];

  // Writes from the load commands.
  always_ff @(posedge clk) begin
    if (wr.step_we) begin
      step_mem[wr.step_index] <= step_wdata;
    end
    if (wr.note_we) begin
      note_mem[wr.note_index] <= note_wdata;
    end
  end

  // Each table is read at the current sequence position only.
  assign step_rdata = step_mem[step_raddr];
  assign note_rdata = note_mem[note_raddr];

endmodule
`default_nettype wire

/* rtl/core/lbps_core.sv */
`default_nettype none
module lbps_core
  import lbps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               item_valid,
  input  wire item_t              item,
  output logic                    proc_ready,
  output tbl_wr_t                 tbl_wr,
  output logic [STEP_AW-1:0]      step_raddr,
  output logic [NOTE_AW-1:0]      note_raddr,
  input  wire step_t              step_rdata,
  input  wire note_t              note_rdata,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [2:0]              led_rgb,
  output logic                    buzzer_on,
  output logic [15:0]             buzzer_pitch,
  output logic                    animation_busy,
  output logic                    melody_busy
);

  logic [15:0] default_tone_freq;
  logic [15:0] blink_interval;

  logic [31:0]      now_ms, now_ms_next;
  logic [31:0]      tone_stop_time, tone_stop_time_next;
  logic             buzzer_level, buzzer_level_next;
  logic [15:0]      buzzer_frequency, buzzer_frequency_next;
  logic [2:0]       led_levels, led_levels_next;
  logic             melody_running, melody_running_next;
  logic [POS_W-1:0] melody_length, melody_length_next;
  logic [POS_W-1:0] melody_position, melody_position_next;
  logic [31:0]      melody_next_time, melody_next_time_next;
  logic             animation_running, animation_running_next;
  logic [POS_W-1:0] animation_length, animation_length_next;
  logic [POS_W-1:0] animation_position, animation_position_next;
  logic [31:0]      animation_next_time, animation_next_time_next;
  logic [31:0]      blink_last_time, blink_last_time_next;
  logic             blink_phase, blink_phase_next;

  logic             fire;
  logic [31:0]      now_inc;
  logic [31:0]      blink_age;

  // The result register frees up whenever its request is taken.
  assign proc_ready = !out_valid || !out_stall;
  assign fire       = item_valid && proc_ready;

  assign step_raddr = animation_position[STEP_AW-1:0];
  assign note_raddr = melody_position[NOTE_AW-1:0];

  // Table writes go straight from the input register.
  always_comb begin
    tbl_wr.step_we    = fire && (item.cmd == CMD_WRITE_STEP)
                        && (32'(item.entry_index) < 32'(STEP_DEPTH));
    tbl_wr.note_we    = fire && (item.cmd == CMD_WRITE_NOTE)
                        && (32'(item.entry_index) < 32'(NOTE_DEPTH));
    tbl_wr.step_index = item.entry_index[STEP_AW-1:0];
    tbl_wr.note_index = item.entry_index[NOTE_AW-1:0];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      default_tone_freq <= DEFAULT_TONE_FREQ_RST;
      blink_interval    <= BLINK_INTERVAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEFAULT_TONE_FREQ: default_tone_freq <= cfg_data;
        CFG_BLINK_INTERVAL:    blink_interval    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign now_inc   = now_ms + 32'd1;
  assign blink_age = now_inc - blink_last_time;

  // Next state for one request: a tick runs tone expiry, melody, animation
  // and status in that order; other commands update the sequencer setup.
  always_comb begin
    now_ms_next              = now_ms;
    tone_stop_time_next      = tone_stop_time;
    buzzer_level_next        = buzzer_level;
    buzzer_frequency_next    = buzzer_frequency;
    led_levels_next          = led_levels;
    melody_running_next      = melody_running;
    melody_length_next       = melody_length;
    melody_position_next     = melody_position;
    melody_next_time_next    = melody_next_time;
    animation_running_next   = animation_running;
    animation_length_next    = animation_length;
    animation_position_next  = animation_position;
    animation_next_time_next = animation_next_time;
    blink_last_time_next     = blink_last_time;
    blink_phase_next         = blink_phase;

    case (item.cmd)
      CMD_TICK: begin
        now_ms_next = now_inc;

        // Expired tone goes quiet and the default frequency returns.
        if ((tone_stop_time != 32'd0) && (now_inc >= tone_stop_time)) begin
          buzzer_level_next     = 1'b0;
          tone_stop_time_next   = 32'd0;
          buzzer_frequency_next = default_tone_freq;
        end

        // Next melody note.
        if (melody_running && (now_inc >= melody_next_time)) begin
          if (melody_position < melody_length) begin
            buzzer_frequency_next = note_rdata.freq;
            buzzer_level_next     = 1'b1;
            melody_next_time_next = now_inc + 32'(note_rdata.dur);
            tone_stop_time_next   = now_inc + 32'(note_rdata.dur);
            melody_position_next  = melody_position + POS_W'(1);
          end else begin
            melody_running_next = 1'b0;
          end
        end

        // Next animation step.
        if (animation_running && (now_inc >= animation_next_time)) begin
          if (animation_position < animation_length) begin
            if (!step_rdata.keep) begin
              led_levels_next = step_rdata.rgb;
            end
            if ((step_rdata.freq != 16'd0) && (step_rdata.tdur != 16'd0)) begin
              buzzer_frequency_next = step_rdata.freq;
              buzzer_level_next     = 1'b1;
              tone_stop_time_next   = now_inc + 32'(step_rdata.tdur);
            end
            animation_next_time_next = now_inc + 32'(step_rdata.sdur);
            animation_position_next  = animation_position + POS_W'(1);
          end else begin
            animation_running_next = 1'b0;
            led_levels_next        = RGB_OFF;
          end
        end

        // Status color while no animation runs.
        if (!animation_running_next) begin
          case (item.status_class)
            CLS_YELLOW:  led_levels_next = RGB_YELLOW;
            CLS_BLUE:    led_levels_next = RGB_BLUE;
            CLS_GREEN:   led_levels_next = RGB_GREEN;
            CLS_CYAN:    led_levels_next = RGB_CYAN;
            CLS_MAGENTA: led_levels_next = RGB_MAGENTA;
            CLS_ERROR: begin
              if (blink_age > 32'(blink_interval)) begin
                blink_phase_next     = !blink_phase;
                led_levels_next      = blink_phase ? RGB_OFF : RGB_RED;
                blink_last_time_next = now_inc;
              end
            end
            default: led_levels_next = RGB_OFF;
          endcase
        end
      end

      CMD_START_ANIM: begin
        animation_running_next   = 1'b1;
        animation_length_next    = (32'(item.sequence_count) > 32'(STEP_DEPTH))
                                   ? POS_W'(STEP_DEPTH) : item.sequence_count;
        animation_position_next  = '0;
        animation_next_time_next = now_ms;
      end

      CMD_START_MEL: begin
        if (item.sequence_count == '0) begin
          melody_running_next = 1'b0;
        end else begin
          melody_running_next   = 1'b1;
          melody_length_next    = (32'(item.sequence_count) > 32'(NOTE_DEPTH))
                                  ? POS_W'(NOTE_DEPTH) : item.sequence_count;
          melody_position_next  = '0;
          melody_next_time_next = now_ms;
        end
      end

      CMD_TONE: begin
        buzzer_frequency_next = item.tone_freq;
        buzzer_level_next     = 1'b1;
        tone_stop_time_next   = now_ms + 32'(item.tone_duration);
      end

      default: ;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms              <= '0;
      tone_stop_time      <= '0;
      buzzer_level        <= 1'b0;
      buzzer_frequency    <= DEFAULT_TONE_FREQ_RST;
      led_levels          <= RGB_OFF;
      melody_running      <= 1'b0;
      melody_length       <= '0;
      melody_position     <= '0;
      melody_next_time    <= '0;
      animation_running   <= 1'b0;
      animation_length    <= '0;
      animation_position  <= '0;
      animation_next_time <= '0;
      blink_last_time     <= '0;
      blink_phase         <= 1'b0;
    end else if (fire) begin
      now_ms              <= now_ms_next;
      tone_stop_time      <= tone_stop_time_next;
      buzzer_level        <= buzzer_level_next;
      buzzer_frequency    <= buzzer_frequency_next;
      led_levels          <= led_levels_next;
      melody_running      <= melody_running_next;
      melody_length       <= melody_length_next;
      melody_position     <= melody_position_next;
      melody_next_time    <= melody_next_time_next;
      animation_running   <= animation_running_next;
      animation_length    <= animation_length_next;
      animation_position  <= animation_position_next;
      animation_next_time <= animation_next_time_next;
      blink_last_time     <= blink_last_time_next;
      blink_phase         <= blink_phase_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      led_rgb        <= led_levels_next;
      buzzer_on      <= buzzer_level_next;
      buzzer_pitch   <= buzzer_frequency_next;
      animation_busy <= animation_running_next;
      melody_busy    <= melody_running_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/led_buzzer_pattern_sequencer.sv */
// Channel   Direction  Handshake            Contents
// in        request    in_valid / in_stall  cmd, entry_index, step and tone fields, class
// out       result     out_valid / out_stall LED levels, buzzer state, busy flags
// cfg       write      cfg_write            cfg_index, cfg_data
//
// Each request passes from acceptance through the input register, then the
// sequencer logic into the result register. Unless the result side stalls,
// one request is accepted every cycle; the throughput is set by the single
// state update per request, which reads one step and one note table entry.
// Reset is synchronous and returns all sequencer state to idle; the tables
// keep their contents. A stall on the result side holds both registers.
`default_nettype none
module led_buzzer_pattern_sequencer
  import lbps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [4:0]  entry_index,
  input  wire logic        color_keep,
  input  wire logic [2:0]  color_rgb,
  input  wire logic [15:0] tone_freq,
  input  wire logic [15:0] tone_duration,
  input  wire logic [15:0] step_duration,
  input  wire logic [5:0]  sequence_count,
  input  wire logic [2:0]  status_class,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             led_red,
  output logic             led_green,
  output logic             led_blue,
  output logic             buzzer_on,
  output logic [15:0]      buzzer_pitch,
  output logic             animation_busy,
  output logic             melody_busy
);

  item_t              in_item;
  item_t              item;
  logic               item_valid;
  logic               proc_ready;
  tbl_wr_t            tbl_wr;
  step_t              step_wdata;
  note_t              note_wdata;
  logic [STEP_AW-1:0] step_raddr;
  logic [NOTE_AW-1:0] note_raddr;
  step_t              step_rdata;
  note_t              note_rdata;
  logic [2:0]         led_rgb;

  // Gather the request fields.
  always_comb begin
    in_item.cmd            = cmd;
    in_item.entry_index    = entry_index;
    in_item.color_keep     = color_keep;
    in_item.color_rgb      = color_rgb;
    in_item.tone_freq      = tone_freq;
    in_item.tone_duration  = tone_duration;
    in_item.step_duration  = step_duration;
    in_item.sequence_count = sequence_count;
    in_item.status_class   = status_class;
  end

  // Table entries built from the registered request.
  always_comb begin
    step_wdata.keep = item.color_keep;
    step_wdata.rgb  = item.color_rgb;
    step_wdata.freq = item.tone_freq;
    step_wdata.tdur = item.tone_duration;
    step_wdata.sdur = item.step_duration;
    note_wdata.freq = item.tone_freq;
    note_wdata.dur  = item.tone_duration;
  end

  lbps_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .proc_ready (proc_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  lbps_tables u_tables (
    .clk        (clk),
    .wr         (tbl_wr),
    .step_wdata (step_wdata),
    .note_wdata (note_wdata),
    .step_raddr (step_raddr),
    .note_raddr (note_raddr),
    .step_rdata (step_rdata),
    .note_rdata (note_rdata)
  );

  lbps_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item           (item),
    .proc_ready     (proc_ready),
    .tbl_wr         (tbl_wr),
    .step_raddr     (step_raddr),
    .note_raddr     (note_raddr),
    .step_rdata     (step_rdata),
    .note_rdata     (note_rdata),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .led_rgb        (led_rgb),
    .buzzer_on      (buzzer_on),
    .buzzer_pitch   (buzzer_pitch),
    .animation_busy (animation_busy),
    .melody_busy    (melody_busy)
  );

  assign led_red   = led_rgb[2];
  assign led_green = led_rgb[1];
  assign led_blue  = led_rgb[0];

endmodule
`default_nettype wire
